/* hdl/fdp_pkg.sv */
// Shared constants, types and helper functions for the float dot product accumulator.
package fdp_pkg;

  // Element pairs carried by one item
  localparam int LANES = 4;
  // Width of a saturated lane count, able to hold LANES itself
  localparam int CW = $clog2(LANES + 1);
  // Width of a lane index
  localparam int IW = (LANES > 1) ? $clog2(LANES) : 1;

  localparam logic [31:0] QNAN = 32'h7FC0_0000;
  localparam logic [7:0]  EXP_MAX = 8'hFF;

  typedef logic [31:0] f32_t;

  // Count leading zeros of a 48-bit word; all zeros gives 48
  function automatic logic [5:0] clz48(input logic [47:0] v);
    logic [5:0] n;
    n = 6'd48;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) begin
        n = 6'(47 - i);
      end
    end
    return n;
  endfunction

  // True for any NaN bit pattern
  function automatic logic is_nan(input f32_t v);
    return (v[30:23] == EXP_MAX) && (v[22:0] != 23'd0);
  endfunction

endpackage

/* hdl/fdp_if.sv */
// Valid/ready channel interfaces for the input items and the result items.
interface fdp_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] x_lane0;
  logic [31:0] y_lane0;
  logic [31:0] x_lane1;
  logic [31:0] y_lane1;
  logic [31:0] x_lane2;
  logic [31:0] y_lane2;
  logic [31:0] x_lane3;
  logic [31:0] y_lane3;
  logic [2:0]  lane_count;
  logic        last_item;

  modport source (
    output valid, x_lane0, y_lane0, x_lane1, y_lane1, x_lane2, y_lane2,
           x_lane3, y_lane3, lane_count, last_item,
    input  ready
  );
  modport sink (
    input  valid, x_lane0, y_lane0, x_lane1, y_lane1, x_lane2, y_lane2,
           x_lane3, y_lane3, lane_count, last_item,
    output ready
  );
endinterface

interface fdp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] dot_value;

  modport source (output valid, dot_value, input ready);
  modport sink (input valid, dot_value, output ready);
endinterface

/* hdl/float_dot_product_accumulator.sv */
// A full item passes the multiply register, loaded at its accepting edge, then LANES-1 group-sum
// stages and one accumulate stage on its way to the output register.
// Throughput: one full item per cycle while no last item waits for the output; the adder loop is combinational.
// An item with c valid lanes, 0 < c < LANES, holds the accumulate stage while it adds one lane at a time.
// Reset clears all stage valids and the output valid and sets the sum to positive zero.
module float_dot_product_accumulator
  import fdp_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  fdp_in_if.sink       req,
  fdp_out_if.source    rsp
);

  localparam int T = LANES - 1;

  f32_t            xs [LANES];
  f32_t            ys [LANES];
  f32_t            prod [LANES];
  f32_t            grp_sum [LANES];
  logic [CW-1:0]   cnt_in;

  logic            st_v    [LANES];
  f32_t            st_prod [LANES][LANES];
  f32_t            st_grp  [LANES];
  logic [CW-1:0]   st_cnt  [LANES];
  logic            st_last [LANES];

  f32_t            acc;
  logic [IW-1:0]   idx;
  f32_t            opnd, acc_sum, res;
  logic            out_valid;
  f32_t            out_value;
  logic            tv, full, zero, done, out_free, consume, step, en;

  assign xs[0] = req.x_lane0;
  assign ys[0] = req.y_lane0;
  assign xs[1] = req.x_lane1;
  assign ys[1] = req.y_lane1;
  assign xs[2] = req.x_lane2;
  assign ys[2] = req.y_lane2;
  assign xs[3] = req.x_lane3;
  assign ys[3] = req.y_lane3;

  // Saturate the lane count at LANES
  assign cnt_in = (32'(req.lane_count) >= LANES) ? CW'(LANES) : CW'(req.lane_count);

  // One multiplier per lane
  for (genvar l = 0; l < LANES; l++) begin : g_mul
    fdp_fmul u_mul (.a(ys[l]), .b(xs[l]), .y(prod[l]));
  end

  // Group sum chain, one adder per group-sum stage
  assign grp_sum[0] = prod[0];
  for (genvar k = 1; k < LANES; k++) begin : g_grp
    fdp_fadd u_add (.a(st_grp[k-1]), .b(st_prod[k-1][k]), .y(grp_sum[k]));
  end

  // Accumulate stage control
  assign tv       = st_v[T];
  assign full     = (st_cnt[T] == CW'(LANES));
  assign zero     = (st_cnt[T] == CW'(0));
  assign done     = full || zero || ((32'(idx) + 1) == 32'(st_cnt[T]));
  assign out_free = !out_valid || rsp.ready;
  assign consume  = tv && done && (!st_last[T] || out_free);
  assign step     = tv && !zero && (!done || consume);
  assign en       = !tv || consume;
  assign opnd     = full ? st_grp[T] : st_prod[T][idx];
  assign res      = zero ? acc : acc_sum;

  fdp_fadd u_acc_add (.a(acc), .b(opnd), .y(acc_sum));

  assign req.ready     = en;
  assign rsp.valid     = out_valid;
  assign rsp.dot_value = out_value;

  // Advance stage valids
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < LANES; k++) begin
        st_v[k] <= 1'b0;
      end
    end else if (en) begin
      st_v[0] <= req.valid;
      for (int k = 1; k < LANES; k++) begin
        st_v[k] <= st_v[k-1];
      end
    end
  end

  // Advance stage payloads
  always_ff @(posedge clk) begin
    if (en) begin
      for (int l = 0; l < LANES; l++) begin
        st_prod[0][l] <= prod[l];
      end
      st_grp[0]  <= grp_sum[0];
      st_cnt[0]  <= cnt_in;
      st_last[0] <= req.last_item;
      for (int k = 1; k < LANES; k++) begin
        st_prod[k] <= st_prod[k-1];
        st_grp[k]  <= grp_sum[k];
        st_cnt[k]  <= st_cnt[k-1];
        st_last[k] <= st_last[k-1];
      end
    end
  end

  // Accumulate, step through partial items, and emit on the last item
  always_ff @(posedge clk) begin
    if (rst) begin
      acc       <= 32'd0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (step) begin
        acc <= acc_sum;
      end
      if (consume) begin
        idx <= '0;
        if (st_last[T]) begin
          acc <= 32'd0;
        end
      end else if (step) begin
        idx <= idx + IW'(1);
      end
      if (consume && st_last[T]) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Capture the result item
  always_ff @(posedge clk) begin
    if (consume && st_last[T]) begin
      out_value <= is_nan(res) ? QNAN : res;
    end
  end

`ifndef SYNTH
  a_busy_stalls: assert property (@(posedge clk) disable iff (rst)
    (tv && !done) |-> !req.ready)
    else $error("input taken while a partial item is still stepping");

  a_clear_after_last: assert property (@(posedge clk) disable iff (rst)
    (consume && st_last[T]) |=> (acc == 32'd0))
    else $error("sum not cleared after the last item");

  a_idx_idle: assert property (@(posedge clk) disable iff (rst)
    !tv |-> (idx == '0))
    else $error("lane index left nonzero with no item in the accumulate stage");

  a_nan_canonical: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && is_nan(rsp.dot_value)) |-> (rsp.dot_value == QNAN))
    else $error("NaN result not canonical");
`endif

endmodule

/* hdl/fdp_fmul.sv */
// Binary32 multiplier, round to nearest even, gradual underflow.
module fdp_fmul
  import fdp_pkg::*;
(
  input  f32_t a,
  input  f32_t b,
  output f32_t y
);

  always_comb begin
    logic              a_nan, b_nan, a_inf, b_inf, a_zero, b_zero, sgn;
    logic [8:0]        ea, eb, e, ef;
    logic [23:0]       ma, mb, mant;
    logic [47:0]       p, pn, q;
    logic [5:0]        lz, r;
    logic signed [10:0] eb_s, rr;
    logic [95:0]       wide;
    logic              g, st, ru;
    logic [24:0]       mr;
    logic [22:0]       frac;

    a_nan  = is_nan(a);
    b_nan  = is_nan(b);
    a_inf  = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf  = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
    a_zero = (a[30:0] == 31'd0);
    b_zero = (b[30:0] == 31'd0);
    sgn    = a[31] ^ b[31];

    // Unpack, treating subnormals as exponent one without hidden bit
    ea = (a[30:23] == 8'd0) ? 9'd1 : {1'b0, a[30:23]};
    eb = (b[30:23] == 8'd0) ? 9'd1 : {1'b0, b[30:23]};
    ma = {(a[30:23] != 8'd0), a[22:0]};
    mb = {(b[30:23] != 8'd0), b[22:0]};

    // Multiply and normalize the leading one to the top
    p    = ma * mb;
    lz   = clz48(p);
    pn   = p << lz;
    eb_s = $signed({2'b00, ea}) + $signed({2'b00, eb}) - 11'sd126
           - $signed({5'b00000, lz});

    // Denormalize when the exponent falls below the normal range
    rr = 11'sd1 - eb_s;
    if (eb_s >= 11'sd1) begin
      r = 6'd0;
      e = eb_s[8:0];
    end else begin
      r = (rr > 11'sd48) ? 6'd48 : rr[5:0];
      e = 9'd1;
    end
    wide = {pn, 48'd0} >> r;
    q    = wide[95:48];
    mant = q[47:24];
    g    = q[23];
    st   = (|q[22:0]) | (|wide[47:0]);

    // Round to nearest even
    ru = g & (st | mant[0]);
    mr = {1'b0, mant} + 25'(ru);
    if (mr[24]) begin
      ef   = e + 9'd1;
      frac = mr[23:1];
    end else begin
      ef   = mr[23] ? e : 9'd0;
      frac = mr[22:0];
    end

    // Select special results
    if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
      y = QNAN;
    end else if (a_inf || b_inf) begin
      y = {sgn, EXP_MAX, 23'd0};
    end else if (a_zero || b_zero) begin
      y = {sgn, 31'd0};
    end else if (ef >= 9'd255) begin
      y = {sgn, EXP_MAX, 23'd0};
    end else begin
      y = {sgn, ef[7:0], frac};
    end
  end

endmodule

/* hdl/fdp_fadd.sv */
// Binary32 adder, round to nearest even, gradual underflow.
module fdp_fadd
  import fdp_pkg::*;
(
  input  f32_t a,
  input  f32_t b,
  output f32_t y
);

  always_comb begin
    logic        a_nan, b_nan, a_inf, b_inf, swap, sub;
    f32_t        big, lit;
    logic [8:0]  eg, el, d, e, ef, lim;
    logic [23:0] mg, ml;
    logic [26:0] gx, lx, lsh, mask, n;
    logic        lst, ru;
    logic [27:0] s;
    logic [5:0]  lz;
    logic [4:0]  sh;
    logic [24:0] mr;
    logic [22:0] frac;

    a_nan = is_nan(a);
    b_nan = is_nan(b);
    a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
    b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);

    // Order operands by magnitude
    swap = (b[30:0] > a[30:0]);
    big  = swap ? b : a;
    lit  = swap ? a : b;
    sub  = big[31] ^ lit[31];
    eg   = (big[30:23] == 8'd0) ? 9'd1 : {1'b0, big[30:23]};
    el   = (lit[30:23] == 8'd0) ? 9'd1 : {1'b0, lit[30:23]};
    mg   = {(big[30:23] != 8'd0), big[22:0]};
    ml   = {(lit[30:23] != 8'd0), lit[22:0]};

    // Align the smaller operand, folding lost bits into sticky
    gx = {mg, 3'b000};
    lx = {ml, 3'b000};
    d  = eg - el;
    if (d >= 9'd27) begin
      lsh  = 27'd0;
      mask = 27'd0;
      lst  = |lx;
    end else begin
      mask = (27'd1 << d[4:0]) - 27'd1;
      lsh  = lx >> d[4:0];
      lst  = |(lx & mask);
    end
    lsh[0] = lsh[0] | lst;

    s = sub ? ({1'b0, gx} - {1'b0, lsh}) : ({1'b0, gx} + {1'b0, lsh});

    // Normalize, stopping at the subnormal boundary
    lz  = clz48({s[26:0], 21'h1F_FFFF});
    lim = eg - 9'd1;
    if ({3'b000, lz} > lim) begin
      sh = lim[4:0];
    end else begin
      sh = lz[4:0];
    end
    if (s[27]) begin
      n = {s[27:2], s[1] | s[0]};
      e = eg + 9'd1;
    end else begin
      n = s[26:0] << sh;
      e = eg - {4'd0, sh};
    end

    // Round to nearest even
    ru = n[2] & (n[1] | n[0] | n[3]);
    mr = {1'b0, n[26:3]} + 25'(ru);
    if (mr[24]) begin
      ef   = e + 9'd1;
      frac = mr[23:1];
    end else begin
      ef   = mr[23] ? e : 9'd0;
      frac = mr[22:0];
    end

    // Select special results
    if (a_nan || b_nan || (a_inf && b_inf && (a[31] ^ b[31]))) begin
      y = QNAN;
    end else if (a_inf) begin
      y = a;
    end else if (b_inf) begin
      y = b;
    end else if (s == 28'd0) begin
      y = {a[31] & b[31], 31'd0};
    end else if (ef >= 9'd255) begin
      y = {big[31], EXP_MAX, 23'd0};
    end else begin
      y = {big[31], ef[7:0], frac};
    end
  end

endmodule
